FILE: sv/pbq_pkg.sv
// Shared constants, codes and control types for the PCM block queue.
`default_nettype none

package pbq_pkg;

  // Queue geometry.
  localparam int MAX_BLOCKS       = 8;
  localparam int FRAMES_PER_BLOCK = 256;
  localparam int SLOT_W           = $clog2(MAX_BLOCKS);
  localparam int IDX_W            = $clog2(FRAMES_PER_BLOCK);
  localparam int CNT_W            = SLOT_W + 1;
  localparam int FILL_W           = IDX_W + 1;
  localparam int ADDR_W           = SLOT_W + IDX_W;
  localparam int DEPTH            = MAX_BLOCKS * FRAMES_PER_BLOCK;

  // Payload widths.
  localparam int SAMPLE_W = 24;
  localparam int FRAME_W  = 2 * SAMPLE_W;
  localparam int TICKET_W = 64;
  localparam int CAP_W    = 4;
  localparam int IN_W     = 120;
  localparam int OUT_W    = 128;

  // Capacity after reset.
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(MAX_BLOCKS);

  // Operation codes.
  typedef enum logic [2:0] {
    OP_PUSH    = 3'd0,
    OP_ACQUIRE = 3'd1,
    OP_RELEASE = 3'd2,
    OP_FINISH  = 3'd3,
    OP_ABORT   = 3'd4,
    OP_READ    = 3'd5
  } op_t;

  // Result status codes.
  typedef enum logic [2:0] {
    STS_OK      = 3'd0,
    STS_INVALID = 3'd1,
    STS_CLOSED  = 3'd2,
    STS_FULL    = 3'd3,
    STS_BUSY    = 3'd4,
    STS_EMPTY   = 3'd5,
    STS_DONE    = 3'd6
  } status_t;

  // Controller states.
  typedef enum logic {
    STATE_IDLE = 1'b0,
    STATE_READ = 1'b1
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    push;
    logic    drop_fill;
    logic    acquire;
    logic    release_blk;
    logic    finish;
    logic    abort;
    logic    mem_rd;
    logic    load;
    logic    load_samples;
    logic    fc_en;
    logic    tk_en;
    status_t status;
  } dp_cmd_t;

  // Queue conditions reported by the datapath.
  typedef struct packed {
    logic closed;
    logic full;
    logic fill_over;
    logic leased;
    logic empty;
    logic tick_max;
    logic tick_match;
    logic read_ok;
  } dp_flags_t;

endpackage

`default_nettype wire

FILE: sv/pcm_block_queue_with_lease_core.sv
// Top level of the PCM block queue with lease.
`default_nettype none

// A ring queue of up to eight blocks of stereo 24-bit frames, each block 1 to 256
// frames long, driven by one op per request on the slave stream (op in tuser,
// frame_last in tlast) and answering each request with exactly one result on the
// master stream. Each op's result is registered on acceptance, except a successful
// read_frame, whose samples are loaded in the READ state because the sample memory
// (2048 x 48 bits) has a registered read port. A new request is taken while the
// previous result waits, as long as that result leaves the output register in the
// same cycle. Writing the capacity register reopens the queue and clears all
// counters, the lease and the ticket; the sample memory needs no clearing pass.
module pcm_block_queue_with_lease_core
  import pbq_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [CAP_W-1:0] cfg_wdata,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  // left_sample[23:0], right_sample[47:24], ticket_in[111:48], frame_index[119:112]
  input  wire logic [IN_W-1:0]  s_tdata,
  // op[2:0]
  input  wire logic [2:0]       s_tuser,
  input  wire logic             s_tlast,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  // status[2:0], ticket_out[66:3], frame_count[75:67], left_out[99:76],
  // right_out[123:100], zero[127:124]
  output logic [OUT_W-1:0]      m_tdata
);

  dp_cmd_t             cmd;
  dp_flags_t           flags;
  logic [2:0]          status;
  logic [TICKET_W-1:0] ticket_out;
  logic [FILL_W-1:0]   frame_count;
  logic [SAMPLE_W-1:0] left_out;
  logic [SAMPLE_W-1:0] right_out;

  // Controller.
  pbq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .op       (s_tuser),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .flags    (flags),
    .cmd      (cmd)
  );

  // Datapath.
  pbq_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .left_sample (s_tdata[23:0]),
    .right_sample(s_tdata[47:24]),
    .frame_last  (s_tlast),
    .ticket_in   (s_tdata[111:48]),
    .frame_index (s_tdata[119:112]),
    .cmd         (cmd),
    .flags       (flags),
    .status      (status),
    .ticket_out  (ticket_out),
    .frame_count (frame_count),
    .left_out    (left_out),
    .right_out   (right_out)
  );

  // Result packing.
  assign m_tdata = {4'b0000, right_out, left_out, frame_count, ticket_out, status};

endmodule

`default_nettype wire

FILE: sv/pbq_ram.sv
// Generic simple dual-port RAM with registered read data.
`default_nettype none

module pbq_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: sv/pbq_ctrl.sv
// Controller: handshake, op decode and the read-wait state machine.
`default_nettype none

module pbq_ctrl
  import pbq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire logic [2:0] op,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire dp_flags_t flags,
  output dp_cmd_t        cmd
);

  state_t state, state_next;
  logic   out_valid_next;
  logic   accept;

  // State and output-valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= STATE_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state, commands and handshake.
  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.status     = STS_INVALID;
    in_ready       = (state == STATE_IDLE) && (!out_valid || out_ready);
    accept         = in_valid && in_ready;
    out_valid_next = out_valid && !out_ready;

    case (state)
      STATE_IDLE: begin
        if (accept) begin
          cmd.load       = 1'b1;
          out_valid_next = 1'b1;
          case (op_t'(op))
            OP_PUSH: begin
              if (flags.closed) begin
                cmd.status = STS_CLOSED;
              end else if (flags.full) begin
                cmd.status = STS_FULL;
              end else if (flags.fill_over) begin
                cmd.drop_fill = 1'b1;
              end else begin
                cmd.push   = 1'b1;
                cmd.status = STS_OK;
              end
            end
            OP_ACQUIRE: begin
              if (flags.leased) begin
                cmd.status = STS_BUSY;
              end else if (flags.empty) begin
                cmd.status = flags.closed ? STS_DONE : STS_EMPTY;
              end else if (!flags.tick_max) begin
                cmd.acquire = 1'b1;
                cmd.fc_en   = 1'b1;
                cmd.tk_en   = 1'b1;
                cmd.status  = STS_OK;
              end
            end
            OP_RELEASE: begin
              if (flags.leased && flags.tick_match && !flags.empty) begin
                cmd.release_blk = 1'b1;
                cmd.status      = STS_OK;
              end
            end
            OP_FINISH: begin
              cmd.finish = 1'b1;
              cmd.status = STS_OK;
            end
            OP_ABORT: begin
              cmd.abort  = 1'b1;
              cmd.status = STS_OK;
            end
            OP_READ: begin
              if (flags.leased) begin
                cmd.fc_en = 1'b1;
                if (flags.read_ok) begin
                  // The samples arrive from the memory's registered read port in the next cycle.
                  cmd.mem_rd     = 1'b1;
                  cmd.status     = STS_OK;
                  out_valid_next = 1'b0;
                  state_next     = STATE_READ;
                end
              end
            end
            default: begin
              cmd.status = STS_INVALID;
            end
          endcase
        end
      end
      STATE_READ: begin
        cmd.load_samples = 1'b1;
        out_valid_next   = 1'b1;
        state_next       = STATE_IDLE;
      end
      default: begin
        state_next = STATE_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/pbq_datapath.sv
// Datapath: queue counters, ticket, block lengths, sample memory and result registers.
`default_nettype none

module pbq_datapath
  import pbq_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [CAP_W-1:0]    cfg_wdata,
  input  wire logic [SAMPLE_W-1:0] left_sample,
  input  wire logic [SAMPLE_W-1:0] right_sample,
  input  wire logic                frame_last,
  input  wire logic [TICKET_W-1:0] ticket_in,
  input  wire logic [IDX_W-1:0]    frame_index,
  input  wire dp_cmd_t             cmd,
  output dp_flags_t                flags,
  output logic [2:0]               status,
  output logic [TICKET_W-1:0]      ticket_out,
  output logic [FILL_W-1:0]        frame_count,
  output logic [SAMPLE_W-1:0]      left_out,
  output logic [SAMPLE_W-1:0]      right_out
);

  logic [CAP_W-1:0]    cap;
  logic [SLOT_W-1:0]   head_slot;
  logic [CNT_W-1:0]    used_count;
  logic                lease_flag;
  logic                closed_flag;
  logic [TICKET_W-1:0] ticket_counter;
  logic [FILL_W-1:0]   fill_count;
  logic [FILL_W-1:0]   block_frames [MAX_BLOCKS];

  logic [CAP_W-1:0]    cap_next;
  logic [CAP_W-1:0]    tail_sum;
  logic [SLOT_W-1:0]   tail_slot;
  logic [CAP_W-1:0]    head_inc;
  logic [SLOT_W-1:0]   head_wrap;
  logic [FILL_W-1:0]   fill_inc;
  logic [TICKET_W-1:0] ticket_inc;
  logic [FILL_W-1:0]   head_frames;
  logic [FRAME_W-1:0]  rd_frame;
  logic                clear_all;

  // Capacity written out of range is clamped to one block or the ring size.
  always_comb begin
    if (cfg_wdata == '0) begin
      cap_next = CAP_W'(1);
    end else if (cfg_wdata > CAP_W'(MAX_BLOCKS)) begin
      cap_next = CAP_W'(MAX_BLOCKS);
    end else begin
      cap_next = cfg_wdata;
    end
  end

  // Ring arithmetic: the sum never reaches twice the capacity.
  always_comb begin
    tail_sum  = CAP_W'(head_slot) + CAP_W'(used_count);
    if (tail_sum >= cap) begin
      tail_sum = tail_sum - cap;
    end
    tail_slot = tail_sum[SLOT_W-1:0];
    head_inc  = CAP_W'(head_slot) + CAP_W'(1);
    head_wrap = (head_inc == cap) ? '0 : head_inc[SLOT_W-1:0];
  end

  assign fill_inc    = fill_count + FILL_W'(1);
  assign ticket_inc  = ticket_counter + TICKET_W'(1);
  assign head_frames = block_frames[head_slot];
  assign clear_all   = rst || cfg_we;

  // Queue conditions for the controller.
  always_comb begin
    flags.closed     = closed_flag;
    flags.full       = CAP_W'(used_count) >= cap;
    flags.fill_over  = fill_count >= FILL_W'(FRAMES_PER_BLOCK);
    flags.leased     = lease_flag;
    flags.empty      = (used_count == '0);
    flags.tick_max   = &ticket_counter;
    flags.tick_match = (ticket_in == ticket_counter);
    flags.read_ok    = FILL_W'(frame_index) < head_frames;
  end

  // Capacity register; a write also reopens the queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= CAP_RESET;
    end else if (cfg_we) begin
      cap <= cap_next;
    end
  end

  // Queue control state.
  always_ff @(posedge clk) begin
    if (clear_all) begin
      head_slot      <= '0;
      used_count     <= '0;
      lease_flag     <= 1'b0;
      closed_flag    <= 1'b0;
      ticket_counter <= '0;
      fill_count     <= '0;
    end else begin
      if (cmd.push) begin
        if (frame_last) begin
          used_count <= used_count + CNT_W'(1);
          fill_count <= '0;
        end else begin
          fill_count <= fill_inc;
        end
      end
      if (cmd.drop_fill) begin
        fill_count <= '0;
      end
      if (cmd.acquire) begin
        ticket_counter <= ticket_inc;
        lease_flag     <= 1'b1;
      end
      if (cmd.release_blk) begin
        lease_flag <= 1'b0;
        head_slot  <= head_wrap;
        used_count <= used_count - CNT_W'(1);
      end
      if (cmd.finish) begin
        closed_flag <= 1'b1;
        fill_count  <= '0;
      end
      if (cmd.abort) begin
        closed_flag <= 1'b1;
        fill_count  <= '0;
        used_count  <= lease_flag ? CNT_W'(1) : CNT_W'(0);
      end
    end
  end

  // Frame count of each committed block.
  always_ff @(posedge clk) begin
    if (cmd.push && frame_last) begin
      block_frames[tail_slot] <= fill_inc;
    end
  end

  // Sample memory, one row of frames per ring slot.
  pbq_ram #(
    .WIDTH(FRAME_W),
    .DEPTH(DEPTH)
  ) u_samples (
    .clk  (clk),
    .we   (cmd.push),
    .waddr({tail_slot, fill_count[IDX_W-1:0]}),
    .wdata({left_sample, right_sample}),
    .re   (cmd.mem_rd),
    .raddr({head_slot, frame_index}),
    .rdata(rd_frame)
  );

  // Result registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status      <= cmd.status;
      ticket_out  <= cmd.tk_en ? ticket_inc : '0;
      frame_count <= cmd.fc_en ? head_frames : '0;
      left_out    <= '0;
      right_out   <= '0;
    end
    if (cmd.load_samples) begin
      left_out  <= rd_frame[FRAME_W-1:SAMPLE_W];
      right_out <= rd_frame[SAMPLE_W-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for the PCM block queue with lease, with its own queue predictor.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pbq_pkg::*;

  // Op codes that the block does not define; both must answer invalid.
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  // One request on the slave stream, field by field.
  typedef struct packed {
    logic [2:0]          op;
    logic [SAMPLE_W-1:0] left;
    logic [SAMPLE_W-1:0] right;
    logic                last;
    logic [TICKET_W-1:0] ticket;
    logic [IDX_W-1:0]    index;
  } queue_request_t;

  // One result on the master stream, field by field.
  typedef struct packed {
    status_t             status;
    logic [TICKET_W-1:0] ticket;
    logic [FILL_W-1:0]   count;
    logic [SAMPLE_W-1:0] left;
    logic [SAMPLE_W-1:0] right;
  } queue_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [CAP_W-1:0] cfg_wdata = '0;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic [2:0]       s_tuser = '0;
  logic             s_tlast = 1'b0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  // Predicted queue state, kept in step with every accepted request.
  logic [CAP_W-1:0]    q_capacity = CAP_RESET;
  int unsigned         q_head = 0;
  int unsigned         q_used = 0;
  int unsigned         q_fill = 0;
  bit                  q_leased = 1'b0;
  bit                  q_closed = 1'b0;
  logic [TICKET_W-1:0] q_ticket = '0;
  int unsigned         q_block_len [MAX_BLOCKS];
  logic [SAMPLE_W-1:0] q_left_mem [DEPTH];
  logic [SAMPLE_W-1:0] q_right_mem [DEPTH];

  queue_result_t expected_results [$];
  int            mismatches = 0;
  int unsigned   requests_sent = 0;
  int            send_idle_pct = 24;
  int            recv_idle_pct = 49;
  int            rx_hold_cycles = 0;

  pcm_block_queue_with_lease_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Works out the result of one request and advances the predicted queue state.
  function automatic queue_result_t predict_queue_result(queue_request_t req);
    queue_result_t res;
    int unsigned   slots;
    int unsigned   tail;
    res = '0;
    res.status = STS_INVALID;
    if (q_capacity == 0) slots = 1;
    else if (q_capacity > MAX_BLOCKS) slots = MAX_BLOCKS;
    else slots = q_capacity;
    case (req.op)
      OP_PUSH: begin
        if (q_closed) begin
          res.status = STS_CLOSED;
        end else if (q_used >= slots) begin
          res.status = STS_FULL;
        end else if (q_fill >= FRAMES_PER_BLOCK) begin
          // The block grew too long: its staged frames are thrown away.
          q_fill = 0;
        end else begin
          tail = (q_head + q_used) % slots;
          q_left_mem[tail * FRAMES_PER_BLOCK + q_fill] = req.left;
          q_right_mem[tail * FRAMES_PER_BLOCK + q_fill] = req.right;
          q_fill++;
          if (req.last) begin
            q_block_len[tail] = q_fill;
            q_used++;
            q_fill = 0;
          end
          res.status = STS_OK;
        end
      end
      OP_ACQUIRE: begin
        if (q_leased) begin
          res.status = STS_BUSY;
        end else if (q_used == 0) begin
          res.status = q_closed ? STS_DONE : STS_EMPTY;
        end else if (q_ticket != '1) begin
          q_ticket++;
          q_leased = 1'b1;
          res.ticket = q_ticket;
          res.count = FILL_W'(q_block_len[q_head]);
          res.status = STS_OK;
        end
      end
      OP_RELEASE: begin
        if (q_leased && req.ticket == q_ticket && q_used > 0) begin
          q_leased = 1'b0;
          q_head = (q_head + 1) % slots;
          q_used--;
          res.status = STS_OK;
        end
      end
      OP_FINISH: begin
        q_closed = 1'b1;
        q_fill = 0;
        res.status = STS_OK;
      end
      OP_ABORT: begin
        // Only a leased head block survives an abort.
        q_closed = 1'b1;
        q_fill = 0;
        q_used = q_leased ? 1 : 0;
        res.status = STS_OK;
      end
      OP_READ: begin
        if (q_leased) begin
          res.count = FILL_W'(q_block_len[q_head]);
          if (req.index < q_block_len[q_head]) begin
            res.left = q_left_mem[q_head * FRAMES_PER_BLOCK + req.index];
            res.right = q_right_mem[q_head * FRAMES_PER_BLOCK + req.index];
            res.status = STS_OK;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic queue_request_t random_request(logic [2:0] op);
    queue_request_t req;
    req.op = op;
    req.left = SAMPLE_W'($urandom);
    req.right = SAMPLE_W'($urandom);
    req.last = 1'($urandom_range(1));
    req.ticket = {$urandom, $urandom};
    req.index = IDX_W'($urandom);
    return req;
  endfunction

  // Offers one request after an optional idle gap and records its expected result.
  task automatic send_request(queue_request_t req);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_tdata  <= {req.index, req.ticket, req.right, req.left};
    s_tuser  <= req.op;
    s_tlast  <= req.last;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    expected_results.push_back(predict_queue_result(req));
    requests_sent++;
  endtask

  task automatic send_op(logic [2:0] op);
    send_request(random_request(op));
  endtask

  task automatic push_frame(logic [SAMPLE_W-1:0] left, logic [SAMPLE_W-1:0] right,
                            logic last);
    queue_request_t req;
    req = random_request(OP_PUSH);
    req.left = left;
    req.right = right;
    req.last = last;
    send_request(req);
  endtask

  task automatic push_block(int unsigned frames, bit commit);
    for (int unsigned i = 1; i <= frames; i++) begin
      push_frame(SAMPLE_W'($urandom), SAMPLE_W'($urandom), commit && i == frames);
    end
  endtask

  task automatic read_frame(logic [IDX_W-1:0] index);
    queue_request_t req;
    req = random_request(OP_READ);
    req.index = index;
    send_request(req);
  endtask

  task automatic release_lease(logic [TICKET_W-1:0] ticket);
    queue_request_t req;
    req = random_request(OP_RELEASE);
    req.ticket = ticket;
    send_request(req);
  endtask

  // Stops offering requests and waits until every expected result has arrived.
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Capacity writes reopen the queue, so they only happen with the block idle.
  task automatic write_capacity(logic [CAP_W-1:0] value);
    wait_for_results();
    cfg_wdata <= value;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    q_capacity = value;
    q_head = 0;
    q_used = 0;
    q_fill = 0;
    q_leased = 1'b0;
    q_closed = 1'b0;
    q_ticket = '0;
  endtask

  // Every op, sample extremes and the refusals, starting from the reset capacity.
  task automatic test_basic_ops();
    send_op(OP_ACQUIRE);
    read_frame(0);
    release_lease('0);
    send_op(OP_SPARE_LO);
    send_op(OP_SPARE_HI);
    push_frame(24'h800000, 24'h7fffff, 1'b0);
    push_frame(24'h7fffff, 24'h800000, 1'b0);
    push_frame(24'hffffff, 24'h000000, 1'b1);
    send_op(OP_ACQUIRE);
    send_op(OP_ACQUIRE);
    read_frame(0);
    read_frame(2);
    read_frame(3);
    read_frame(8'hff);
    release_lease('1);
    release_lease(q_ticket);
    send_op(OP_ACQUIRE);
    // Finish drops the staged frame and closes the queue.
    push_frame(SAMPLE_W'($urandom), SAMPLE_W'($urandom), 1'b0);
    send_op(OP_FINISH);
    push_frame(SAMPLE_W'($urandom), SAMPLE_W'($urandom), 1'b1);
    send_op(OP_ACQUIRE);
    send_op(OP_ABORT);
  endtask

  // Capacity values outside the legal range, a full ring and abort with and without lease.
  task automatic test_capacity_extremes();
    write_capacity(4'd0);
    push_block(1, 1'b1);
    push_block(1, 1'b1);
    send_op(OP_ACQUIRE);
    send_op(OP_ABORT);
    push_block(1, 1'b1);
    release_lease(q_ticket);
    send_op(OP_ACQUIRE);
    write_capacity(4'hf);
    repeat (MAX_BLOCKS + 1) push_block(1, 1'b1);
    send_op(OP_ABORT);
    send_op(OP_ACQUIRE);
  endtask

  // A block of the largest size, then one that runs past it and is dropped.
  task automatic test_long_blocks();
    write_capacity(4'd2);
    push_block(FRAMES_PER_BLOCK, 1'b1);
    send_op(OP_ACQUIRE);
    read_frame(IDX_W'(FRAMES_PER_BLOCK - 1));
    read_frame(0);
    release_lease(q_ticket);
    push_block(FRAMES_PER_BLOCK + 1, 1'b0);
    push_block(2, 1'b1);
    send_op(OP_ACQUIRE);
    read_frame(1);
    read_frame(2);
  endtask

  // The receiver holds off for a long stretch while requests keep coming.
  task automatic test_backpressure();
    write_capacity(CAP_W'(MAX_BLOCKS));
    send_idle_pct = 0;
    rx_hold_cycles = 100;
    repeat (MAX_BLOCKS) push_block(3, 1'b1);
    send_op(OP_ACQUIRE);
    repeat (4) read_frame(IDX_W'($urandom_range(3)));
    wait_for_results();
    send_idle_pct = 24;
  endtask

  // Mostly well-formed block traffic and lease cycles, with noise and reconfiguration.
  task automatic test_random_traffic(int unsigned count, int send_pct, int recv_pct);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned len;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    write_capacity(CAP_W'($urandom_range(1, MAX_BLOCKS)));
    stop_at = requests_sent + count;
    while (requests_sent < stop_at) begin
      pick = $urandom_range(99);
      if (q_closed && $urandom_range(3) == 0) begin
        pick = 99;
      end
      if (pick < 36) begin
        len = $urandom_range(99);
        if (len < 80) len = $urandom_range(1, 6);
        else if (len < 99) len = $urandom_range(7, 40);
        else len = $urandom_range(240, FRAMES_PER_BLOCK);
        push_block(len, $urandom_range(19) != 0);
      end else if (pick < 72) begin
        send_op(OP_ACQUIRE);
        if (q_leased) begin
          repeat ($urandom_range(4)) begin
            if ($urandom_range(3) != 0) begin
              read_frame(IDX_W'($urandom_range(q_block_len[q_head] - 1)));
            end else begin
              read_frame(IDX_W'($urandom_range(255)));
            end
          end
          len = $urandom_range(99);
          if (len < 75) release_lease(q_ticket);
          else if (len < 90) release_lease({$urandom, $urandom});
        end
      end else if (pick < 84) begin
        send_op(3'($urandom_range(7)));
      end else if (pick < 88) begin
        send_op(OP_FINISH);
      end else if (pick < 91) begin
        send_op(OP_ABORT);
      end else if ($urandom_range(9) < 7) begin
        write_capacity(CAP_W'($urandom_range(1, MAX_BLOCKS)));
      end else begin
        write_capacity(CAP_W'($urandom_range(15)));
      end
    end
  endtask

  function automatic void check_field(string field, logic [TICKET_W-1:0] want,
                                      logic [TICKET_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      mismatches++;
    end
  endfunction

  // Result side: check each accepted result, then choose the next ready level.
  always @(posedge clk) begin
    queue_result_t want;
    if (!rst && m_tvalid === 1'b1 && m_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("status", TICKET_W'(want.status), TICKET_W'(m_tdata[2:0]));
        check_field("ticket_out", want.ticket, m_tdata[66:3]);
        check_field("frame_count", TICKET_W'(want.count), TICKET_W'(m_tdata[75:67]));
        check_field("left_out", TICKET_W'(want.left), TICKET_W'(m_tdata[99:76]));
        check_field("right_out", TICKET_W'(want.right), TICKET_W'(m_tdata[123:100]));
      end
    end
    if (rx_hold_cycles > 0) begin
      m_tready <= 1'b0;
      rx_hold_cycles--;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_basic_ops();
    test_capacity_extremes();
    test_long_blocks();
    test_backpressure();
    test_random_traffic(400, 24, 49);
    test_random_traffic(400, 49, 24);
    test_random_traffic(400, 0, 0);
    wait_for_results();
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #4_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire
